>>> rtl/aik_pkg.sv
// Package for the arm inverse kinematics block: shared types, codes, angle constants
// and the CORDIC step angle table. No dependencies.
`default_nettype none
package aik_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_REACH = 2'd1,
        ST_AXIS  = 2'd2
    } t_status;

    localparam int SQ_STEPS = 24;   // root bits of a 48-bit radicand
    localparam int CW       = 28;   // CORDIC vector width
    localparam int AW       = 25;   // CORDIC angle accumulator width

    // Angles in units of 2^-16 degree
    localparam logic signed [31:0] DEG90  = 32'sd5898240;
    localparam logic signed [31:0] DEG180 = 32'sd11796480;

    // Flags and base CORDIC operands that ride along with a word
    typedef struct packed {
        t_status            status;
        logic               y_zero;
        logic               x_pos;
        logic               z_pos;
        logic signed [24:0] bx;
        logic signed [24:0] by;
        logic signed [24:0] ez;
    } t_side;

    // One classified word between front and back
    typedef struct packed {
        logic [31:0] s2;
        logic [31:0] r2;
        logic [31:0] diff;
        t_side       side;
    } t_item;

    // atan(2^-i) in units of 2^-16 degree, rounded to nearest
    function automatic logic [21:0] step_angle(input logic [4:0] i);
        logic [21:0] a;
        unique case (i)
            5'd0:  a = 22'd2949120;
            5'd1:  a = 22'd1740967;
            5'd2:  a = 22'd919879;
            5'd3:  a = 22'd466945;
            5'd4:  a = 22'd234379;
            5'd5:  a = 22'd117304;
            5'd6:  a = 22'd58666;
            5'd7:  a = 22'd29335;
            5'd8:  a = 22'd14668;
            5'd9:  a = 22'd7334;
            5'd10: a = 22'd3667;
            5'd11: a = 22'd1833;
            5'd12: a = 22'd917;
            5'd13: a = 22'd458;
            5'd14: a = 22'd229;
            5'd15: a = 22'd115;
            5'd16: a = 22'd57;
            5'd17: a = 22'd29;
            5'd18: a = 22'd14;
            5'd19: a = 22'd7;
            5'd20: a = 22'd4;
            5'd21: a = 22'd2;
            5'd22: a = 22'd1;
            default: a = 22'd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

>>> rtl/aik_front.sv
// Front end: accepts target words, squares the coordinates and classifies reach.
// Depends on aik_pkg.
`default_nettype none
module aik_front
    import aik_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [15:0] i_x,
    input  wire logic signed [15:0] i_y,
    input  wire logic signed [15:0] i_z,
    input  wire logic        [14:0] i_arm_length,
    input  wire logic               i_q_full,
    output logic                    o_push,
    output t_item                   o_item
);

    logic               r_v1, r_v2, en;
    logic signed [15:0] r_x, r_y, r_z;
    logic        [30:0] r_xx, r_yy, r_zz;
    logic        [31:0] r_lim;
    logic signed [31:0] pxx, pyy, pzz;
    logic        [31:0] s2, r2;
    logic               axis, far;
    logic signed [24:0] x8, y8, z8;
    t_item              n_item, r_item;

    // Front moves as one unit unless its last word cannot enter the queue
    assign en      = !r_v2 || !i_q_full;
    assign o_stall = !en;
    assign o_push  = r_v2 && !i_q_full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Reach limit 4*L^2
    always_ff @(posedge i_clk) begin
        r_lim <= {30'(i_arm_length * i_arm_length), 2'b00};
    end

    // Stage 1: squares
    assign pxx = i_x * i_x;
    assign pyy = i_y * i_y;
    assign pzz = i_z * i_z;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x  <= i_x;
            r_y  <= i_y;
            r_z  <= i_z;
            r_xx <= pxx[30:0];
            r_yy <= pyy[30:0];
            r_zz <= pzz[30:0];
        end
    end

    // Stage 2: sums, classification, base operands
    assign s2   = {1'b0, r_xx} + {1'b0, r_yy};
    assign r2   = s2 + {1'b0, r_zz};
    assign axis = (r_x == 16'sd0) && (r_y == 16'sd0);
    assign far  = r2 > r_lim;
    assign x8   = {{1{r_x[15]}}, r_x, 8'd0};
    assign y8   = {{1{r_y[15]}}, r_y, 8'd0};
    assign z8   = {{1{r_z[15]}}, r_z, 8'd0};

    always_comb begin
        n_item      = '0;
        n_item.s2   = s2;
        n_item.r2   = r2;
        n_item.diff = r_lim - r2;
        priority if (axis)  n_item.side.status = ST_AXIS;
        else if (far)       n_item.side.status = ST_REACH;
        else                n_item.side.status = ST_OK;
        n_item.side.y_zero = (r_y == 16'sd0);
        n_item.side.x_pos  = (r_x > 16'sd0);
        n_item.side.z_pos  = (r_z > 16'sd0);
        if (r_y > 16'sd0) begin
            n_item.side.bx = y8;
            n_item.side.by = x8;
        end else begin
            n_item.side.bx = -y8;
            n_item.side.by = -x8;
        end
        n_item.side.ez = r_z[15] ? -z8 : z8;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

>>> rtl/aik_queue.sv
// Four-entry queue of classified words between front and back end.
// Depends on aik_pkg.
`default_nettype none
module aik_queue
    import aik_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_empty,
    output t_item      o_head
);

    t_item      r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    assign o_full  = r_cnt == 3'd4;
    assign o_empty = r_cnt == 3'd0;
    assign o_head  = r_mem[r_rp];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 2'd1;
            if (i_pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(i_push) - 3'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

endmodule
`default_nettype wire

>>> rtl/aik_isqrt.sv
// Pipelined floor square root of a 32-bit value scaled by 2^16, one root bit per stage.
// Depends on aik_pkg.
`default_nettype none
module aik_isqrt
    import aik_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_val,
    output logic      [23:0] o_root
);

    logic [47:0] r_v [SQ_STEPS+1];
    logic [47:0] r_r [SQ_STEPS+1];

    assign r_v[0]  = {i_val, 16'd0};
    assign r_r[0]  = '0;
    assign o_root  = r_r[SQ_STEPS][23:0];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
        localparam logic [47:0] B = 48'd1 << (2 * (SQ_STEPS - 1 - k));
        logic [48:0] trial;
        assign trial = {1'b0, r_r[k]} + {1'b0, B};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if ({1'b0, r_v[k]} >= trial) begin
                    r_v[k+1] <= r_v[k] - trial[47:0];
                    r_r[k+1] <= (r_r[k] >> 1) + B;
                end else begin
                    r_v[k+1] <= r_v[k];
                    r_r[k+1] <= r_r[k] >> 1;
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/aik_cordic.sv
// Pipelined CORDIC in vectoring mode: angle of (x, y) for x >= 0, one step per stage.
// Depends on aik_pkg.
`default_nettype none
module aik_cordic
    import aik_pkg::*;
#(
    parameter int STEPS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic signed [24:0]   i_x,
    input  wire logic signed [24:0]   i_y,
    output logic signed [AW-1:0]      o_ang
);

    logic signed [CW-1:0] r_x [STEPS+1];
    logic signed [CW-1:0] r_y [STEPS+1];
    logic signed [AW-1:0] r_a [STEPS+1];

    assign r_x[0] = CW'(i_x);
    assign r_y[0] = CW'(i_y);
    assign r_a[0] = '0;
    assign o_ang  = r_a[STEPS];

    for (genvar s = 0; s < STEPS; s++) begin : g_stage
        logic signed [AW-1:0] da;
        assign da = $signed(AW'(step_angle(5'(s))));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[s] > 0) begin
                    r_x[s+1] <= r_x[s] + (r_y[s] >>> s);
                    r_y[s+1] <= r_y[s] - (r_x[s] >>> s);
                    r_a[s+1] <= r_a[s] + da;
                end else begin
                    r_x[s+1] <= r_x[s] - (r_y[s] >>> s);
                    r_y[s+1] <= r_y[s] + (r_x[s] >>> s);
                    r_a[s+1] <= r_a[s] - da;
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/aik_back.sv
// Back end: square roots, three CORDIC angle units, angle assembly and output register.
// Depends on aik_pkg, aik_isqrt and aik_cordic.
`default_nettype none
module aik_back
    import aik_pkg::*;
#(
    parameter int STEPS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_avail,
    input  wire t_item              i_item,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [16:0]      o_base_angle,
    output logic signed [16:0]      o_forward_angle,
    output logic signed [16:0]      o_up_angle,
    output logic        [1:0]       o_status
);

    localparam int DEPTH = SQ_STEPS + STEPS;

    logic                 en;
    logic                 r_vd   [DEPTH+1];
    t_side                r_side [DEPTH+1];
    logic          [23:0] ltt, reach, sine;
    logic signed [AW-1:0] a_base, a_sh, a_el;
    logic signed   [31:0] base, rot, a, shoulder, elb;
    logic                 r_pv, r_ov;
    t_status              r_pst;
    logic signed   [31:0] r_rot, r_sh, r_elb;
    logic signed   [31:0] fwd, up;
    logic signed   [31:0] n_b, n_f, n_u;
    logic signed   [16:0] r_b, r_f, r_u;
    t_status              r_st;

    // Whole back end advances unless a finished word is held at the output
    assign en    = !r_ov || !i_stall;
    assign o_pop = en && i_avail;

    assign r_vd[0]   = i_avail;
    assign r_side[0] = i_item.side;

    aik_isqrt u_sq_ltt   (.i_clk, .i_en(en), .i_val(i_item.s2),   .o_root(ltt));
    aik_isqrt u_sq_reach (.i_clk, .i_en(en), .i_val(i_item.r2),   .o_root(reach));
    aik_isqrt u_sq_sine  (.i_clk, .i_en(en), .i_val(i_item.diff), .o_root(sine));

    // Valid and flag line alongside the root and angle pipelines
    for (genvar k = 0; k < DEPTH; k++) begin : g_line
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[k+1] <= 1'b0;
            end else if (en) begin
                r_vd[k+1] <= r_vd[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) r_side[k+1] <= r_side[k];
        end
    end

    aik_cordic #(.STEPS(STEPS)) u_cd_base (
        .i_clk, .i_en(en),
        .i_x(r_side[SQ_STEPS].bx), .i_y(r_side[SQ_STEPS].by), .o_ang(a_base)
    );
    aik_cordic #(.STEPS(STEPS)) u_cd_sh (
        .i_clk, .i_en(en),
        .i_x($signed({1'b0, reach})), .i_y($signed({1'b0, sine})), .o_ang(a_sh)
    );
    aik_cordic #(.STEPS(STEPS)) u_cd_el (
        .i_clk, .i_en(en),
        .i_x($signed({1'b0, ltt})), .i_y(r_side[SQ_STEPS].ez), .o_ang(a_el)
    );

    // Assembly, first half: base rotation, shoulder, elbow magnitude
    always_comb begin
        priority if (!r_side[DEPTH].y_zero) base = 32'(a_base);
        else if (r_side[DEPTH].x_pos)       base = DEG90;
        else                                base = -DEG90;
        rot      = DEG90 - base;
        a        = 32'(a_sh);
        shoulder = r_side[DEPTH].z_pos ? a + 32'(a_el) : a - 32'(a_el);
        elb      = (DEG90 - a) <<< 1;
        if (elb < 0) elb = -elb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_pv <= r_vd[DEPTH];
            r_ov <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rot <= rot;
            r_sh  <= shoulder;
            r_elb <= elb;
            r_pst <= r_side[DEPTH].status;
        end
    end

    // Assembly, second half: servo angles, rounding to degree*64
    assign fwd = DEG180 - r_sh;
    assign up  = r_elb + r_sh;
    assign n_b = (r_rot + 32'sd512) >>> 10;
    assign n_f = (fwd + 32'sd512) >>> 10;
    assign n_u = (up + 32'sd512) >>> 10;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st <= r_pst;
            if (r_pst == ST_OK) begin
                r_b <= n_b[16:0];
                r_f <= n_f[16:0];
                r_u <= n_u[16:0];
            end else begin
                r_b <= '0;
                r_f <= '0;
                r_u <= '0;
            end
        end
    end

    assign o_valid         = r_ov;
    assign o_base_angle    = r_b;
    assign o_forward_angle = r_f;
    assign o_up_angle      = r_u;
    assign o_status        = r_st;

endmodule
`default_nettype wire

>>> rtl/arm_inverse_kinematics.sv
// Arm inverse kinematics: target point in, three servo angles and a status out.
// Top level; depends on aik_pkg, aik_front, aik_queue and aik_back.
//
// Usage:
//   Input channel i_in_valid / o_in_stall carries one target word (x, y, z, Q8.8).
//   Output channel o_out_valid / i_out_stall carries one result word per target:
//   base, forward and up angles in degree*64 and a status (ok, out of reach,
//   point on the vertical axis; angles read 0 unless ok).
//   A word moves at a clock edge with valid high and stall low.
//   Throughput is one word per cycle while neither channel stalls. From accept to
//   output valid a word passes 2 front stages, a queue slot, 24 root stages (one bit
//   of the 24-bit root each), CORDIC_STEPS angle stages and 2 assembly stages.
//   arm_length is written through i_cfg_wr_en / i_cfg_wr_data while idle (the user's
//   duty; the block does not enforce it); the reach limit follows in the next cycle.
//   Reset (i_rst_n low, synchronous) empties every stage and sets arm_length to 2048.
//   When the receiver stalls, the back end holds its pipeline and the four-word
//   queue fills; the input stalls only when the queue and the last front stage are full.
`default_nettype none
module arm_inverse_kinematics
    import aik_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [15:0] i_target_x,
    input  wire logic signed [15:0] i_target_y,
    input  wire logic signed [15:0] i_target_z,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [16:0]      o_base_angle,
    output logic signed [16:0]      o_forward_angle,
    output logic signed [16:0]      o_up_angle,
    output logic        [1:0]       o_status,
    input  wire logic               i_cfg_wr_en,
    input  wire logic        [14:0] i_cfg_wr_data
);

    logic [14:0] r_arm_length;
    logic        q_full, q_empty, push, pop;
    t_item       f_item, q_head;

    // Link length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm_length <= 15'd2048;
        end else if (i_cfg_wr_en) begin
            r_arm_length <= i_cfg_wr_data;
        end
    end

    aik_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(i_in_valid), .o_stall(o_in_stall),
        .i_x(i_target_x), .i_y(i_target_y), .i_z(i_target_z),
        .i_arm_length(r_arm_length),
        .i_q_full(q_full), .o_push(push), .o_item(f_item)
    );

    aik_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push(push), .i_item(f_item), .i_pop(pop),
        .o_full(q_full), .o_empty(q_empty), .o_head(q_head)
    );

    aik_back #(.STEPS(CORDIC_STEPS)) u_back (
        .i_clk, .i_rst_n,
        .i_avail(!q_empty), .i_item(q_head), .o_pop(pop),
        .o_valid(o_out_valid), .i_stall(i_out_stall),
        .o_base_angle, .o_forward_angle, .o_up_angle, .o_status
    );

endmodule
`default_nettype wire
